// File: sv/ils_pkg.sv
package ils_pkg;

  // Stream widths
  localparam int CP_W       = 21;
  localparam int VALUE_W    = 64;
  localparam int LEN_W      = 8;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Literal length saturates here
  localparam logic [LEN_W-1:0] LENGTH_MAX = 8'd255;

  // Character codes
  localparam logic [CP_W-1:0] CH_ZERO  = 21'h30;
  localparam logic [CP_W-1:0] CH_ONE   = 21'h31;
  localparam logic [CP_W-1:0] CH_SEVEN = 21'h37;
  localparam logic [CP_W-1:0] CH_NINE  = 21'h39;
  localparam logic [CP_W-1:0] CH_LC_A  = 21'h61;
  localparam logic [CP_W-1:0] CH_LC_F  = 21'h66;
  localparam logic [CP_W-1:0] CH_LC_Z  = 21'h7A;
  localparam logic [CP_W-1:0] CH_UC_A  = 21'h41;
  localparam logic [CP_W-1:0] CH_UC_F  = 21'h46;
  localparam logic [CP_W-1:0] CH_UC_Z  = 21'h5A;
  localparam logic [CP_W-1:0] CH_LC_X  = 21'h78;
  localparam logic [CP_W-1:0] CH_LC_O  = 21'h6F;
  localparam logic [CP_W-1:0] CH_LC_B  = 21'h62;
  localparam logic [CP_W-1:0] CH_DOT   = 21'h2E;
  localparam logic [CP_W-1:0] CH_MINUS = 21'h2D;
  localparam logic [CP_W-1:0] CH_PLUS  = 21'h2B;
  localparam logic [CP_W-1:0] CH_UNDER = 21'h5F;
  localparam logic [CP_W-1:0] CH_ASCII_END = 21'h80;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INT      = 2'd0,
    ST_NOT_INT  = 2'd1,
    ST_FRACTION = 2'd2
  } status_t;

  // Radix of the literal being scanned
  typedef enum logic [1:0] {
    RS_DEC = 2'd0,
    RS_HEX = 2'd1,
    RS_OCT = 2'd2,
    RS_BIN = 2'd3
  } radix_t;

  // One result item, last field in the low bits when packed to tdata
  typedef struct packed {
    logic [LEN_W-1:0]   length;
    logic               overflow;
    logic [VALUE_W-1:0] value;
    status_t            status;
  } result_t;

endpackage

// File: sv/integer_literal_scanner_unit.sv
// A result is written to the result queue by the transfer that ends its literal.
// Throughput: one codepoint per cycle while the result queue has room; the scan
// step is a combinational constant-radix multiply-add (shift and add) plus compares.
// An item that yields two results writes both to the queue, closing result first.
// Reset: synchronous, clears the scan state to idle and empties the result queue.
module integer_literal_scanner_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [20:0] codepoint, [23:21] zero
  input  logic [ils_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] first, [1] end_of_text
  input  logic [ils_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] status, [65:2] value, [66] overflow, [74:67] length, [79:75] zero
  output logic [ils_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ils_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_ZERO,
    PH_DEC,
    PH_DOT,
    PH_PFX,
    PH_RADIX
  } phase_t;

  // Scan state
  phase_t             phase, phase_next;
  radix_t             radix_sel, radix_sel_next;
  logic               negative, negative_next;
  logic [VALUE_W-1:0] accumulator, accumulator_next;
  logic [LEN_W-1:0]   consumed, consumed_next;
  logic               wrapped, wrapped_next;

  // Result queue
  result_t             queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_CW-1:0] count;

  logic            accept, pop;
  logic [CP_W-1:0] cp;
  logic            first, eot;

  logic is_dec, is_ident, is_hex_lc, is_hex_uc, is_pfx;
  logic dig_ok;
  logic [3:0] dig_val;

  logic [VALUE_W+3:0] product, mac;
  logic [LEN_W-1:0]   consumed_inc;

  result_t res_cur, res_not, res_frac;
  result_t res_a, res_b;
  logic    push_a, push_b;
  result_t w0_data;
  logic    w0_en, w1_en;

  assign cp     = s_axis_tdata[CP_W-1:0];
  assign first  = s_axis_tuser[0];
  assign eot    = s_axis_tuser[1];
  assign accept = s_axis_tvalid && s_axis_tready;

  // Room for two results is always kept before taking an item
  assign s_axis_tready = (count < QUEUE_CW'(QUEUE_DEPTH - 1));
  assign m_axis_tvalid = (count != '0);
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = {(OUT_DATA_W - $bits(result_t))'(0), queue[rd_ptr]};

  // Character classes
  assign is_dec    = (cp >= CH_ZERO) && (cp <= CH_NINE);
  assign is_hex_lc = (cp >= CH_LC_A) && (cp <= CH_LC_F);
  assign is_hex_uc = (cp >= CH_UC_A) && (cp <= CH_UC_F);
  assign is_ident  = ((cp >= CH_LC_A) && (cp <= CH_LC_Z)) ||
                     ((cp >= CH_UC_A) && (cp <= CH_UC_Z)) ||
                     (cp == CH_UNDER) || (cp >= CH_ASCII_END);
  assign is_pfx    = (cp == CH_LC_X) || (cp == CH_LC_O) || (cp == CH_LC_B);

  // Digit of the current radix
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = cp[3:0];
    case (radix_sel)
      RS_HEX: begin
        dig_ok = is_dec || is_hex_lc || is_hex_uc;
        if (!is_dec) begin
          dig_val = cp[3:0] + 4'd9;
        end
      end
      RS_OCT:  dig_ok = (cp >= CH_ZERO) && (cp <= CH_SEVEN);
      RS_BIN:  dig_ok = (cp == CH_ZERO) || (cp == CH_ONE);
      default: dig_ok = is_dec;
    endcase
  end

  // Multiply-add by the radix; carry-out bits flag the wrap
  always_comb begin
    case (radix_sel)
      RS_HEX:  product = {accumulator, 4'b0};
      RS_OCT:  product = {1'b0, accumulator, 3'b0};
      RS_BIN:  product = {3'b0, accumulator, 1'b0};
      default: product = {1'b0, accumulator, 3'b0} + {3'b0, accumulator, 1'b0};
    endcase
    mac = product + {(VALUE_W)'(0), dig_val};
  end

  assign consumed_inc = (consumed == LENGTH_MAX) ? consumed : consumed + LEN_W'(1);

  // Candidate results
  always_comb begin
    res_cur.status   = ST_INT;
    res_cur.value    = negative ? (VALUE_W'(0) - accumulator) : accumulator;
    res_cur.overflow = wrapped;
    res_cur.length   = consumed;
    res_not          = '0;
    res_not.status   = ST_NOT_INT;
    res_frac         = '0;
    res_frac.status  = ST_FRACTION;
  end

  // Scan step
  always_comb begin
    phase_next       = phase;
    radix_sel_next   = radix_sel;
    negative_next    = negative;
    accumulator_next = accumulator;
    consumed_next    = consumed;
    wrapped_next     = wrapped;
    push_a           = 1'b0;
    push_b           = 1'b0;
    res_a            = res_cur;
    res_b            = res_not;

    if (accept) begin
      // End of text or a new start closes an active scan
      if ((eot || first) && (phase != PH_IDLE)) begin
        push_a     = 1'b1;
        res_a      = ((phase == PH_SIGN) || (phase == PH_PFX)) ? res_not : res_cur;
        phase_next = PH_IDLE;
      end

      if (eot) begin
        // no codepoint taken
      end else if (first) begin
        radix_sel_next   = RS_DEC;
        negative_next    = 1'b0;
        accumulator_next = '0;
        consumed_next    = LEN_W'(1);
        wrapped_next     = 1'b0;
        if ((cp == CH_PLUS) || (cp == CH_MINUS)) begin
          negative_next = (cp == CH_MINUS);
          phase_next    = PH_SIGN;
        end else if (cp == CH_ZERO) begin
          phase_next = PH_ZERO;
        end else if (is_dec) begin
          accumulator_next = {(VALUE_W - 4)'(0), cp[3:0]};
          phase_next       = PH_DEC;
        end else begin
          consumed_next = '0;
          push_b        = 1'b1;
          res_b         = res_not;
          phase_next    = PH_IDLE;
        end
      end else begin
        case (phase)
          PH_SIGN: begin
            if (is_dec) begin
              accumulator_next = mac[VALUE_W-1:0];
              wrapped_next     = wrapped | (|mac[VALUE_W+3:VALUE_W]);
              consumed_next    = consumed_inc;
              phase_next       = PH_DEC;
            end else begin
              push_b     = 1'b1;
              res_b      = res_not;
              phase_next = PH_IDLE;
            end
          end
          PH_ZERO, PH_DEC: begin
            if ((phase == PH_ZERO) && is_pfx) begin
              radix_sel_next = (cp == CH_LC_X) ? RS_HEX :
                               (cp == CH_LC_O) ? RS_OCT : RS_BIN;
              consumed_next  = consumed_inc;
              phase_next     = PH_PFX;
            end else if (is_dec) begin
              accumulator_next = mac[VALUE_W-1:0];
              wrapped_next     = wrapped | (|mac[VALUE_W+3:VALUE_W]);
              consumed_next    = consumed_inc;
              phase_next       = PH_DEC;
            end else if (cp == CH_DOT) begin
              phase_next = PH_DOT;
            end else begin
              push_b     = 1'b1;
              res_b      = is_ident ? res_not : res_cur;
              phase_next = PH_IDLE;
            end
          end
          PH_DOT: begin
            push_b     = 1'b1;
            res_b      = is_dec ? res_frac : res_cur;
            phase_next = PH_IDLE;
          end
          PH_PFX: begin
            if (dig_ok) begin
              accumulator_next = mac[VALUE_W-1:0];
              wrapped_next     = wrapped | (|mac[VALUE_W+3:VALUE_W]);
              consumed_next    = consumed_inc;
              phase_next       = PH_RADIX;
            end else begin
              push_b     = 1'b1;
              res_b      = res_not;
              phase_next = PH_IDLE;
            end
          end
          PH_RADIX: begin
            if (dig_ok) begin
              accumulator_next = mac[VALUE_W-1:0];
              wrapped_next     = wrapped | (|mac[VALUE_W+3:VALUE_W]);
              consumed_next    = consumed_inc;
            end else begin
              push_b     = 1'b1;
              res_b      = is_ident ? res_not : res_cur;
              phase_next = PH_IDLE;
            end
          end
          default: begin
            // idle: codepoints outside a scan are dropped
          end
        endcase
      end
    end
  end

  // Queue write ports: closing result first, then the item's own result
  assign w0_en   = push_a || push_b;
  assign w1_en   = push_a && push_b;
  assign w0_data = push_a ? res_a : res_b;

  // State and result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      radix_sel   <= RS_DEC;
      negative    <= 1'b0;
      accumulator <= '0;
      consumed    <= '0;
      wrapped     <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      phase       <= phase_next;
      radix_sel   <= radix_sel_next;
      negative    <= negative_next;
      accumulator <= accumulator_next;
      consumed    <= consumed_next;
      wrapped     <= wrapped_next;
      if (w1_en) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(2);
      end else if (w0_en) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      count <= count + QUEUE_CW'(w0_en) + QUEUE_CW'(w1_en) - QUEUE_CW'(pop);
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk) begin
    if (w0_en) begin
      queue[wr_ptr] <= w0_data;
    end
    if (w1_en) begin
      queue[wr_ptr + QUEUE_AW'(1)] <= res_b;
    end
  end

endmodule
